@@ src/scra_pkg.sv @@
// Shared types and constants for the rotation alarm.
package scra_pkg;

    localparam int SCRA_WINDOW = 10;

    localparam int MOVE_FACTOR = 5;

    localparam logic signed [15:0] POS_SENTINEL = 16'sd23041;
    localparam logic signed [15:0] NEG_SENTINEL = -16'sd23041;

    localparam logic [11:0] THRESHOLD_RST   = 12'd64;
    localparam logic [9:0]  MAX_RUNS_RST    = 10'd100;
    localparam logic [15:0] RESET_TICKS_RST = 16'd300;

    localparam int RUN_W = 11;

    typedef enum logic [1:0] {
        REG_THRESHOLD   = 2'd0,
        REG_MAX_RUNS    = 2'd1,
        REG_RESET_TICKS = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        PHASE_WAIT  = 2'd0,
        PHASE_CAL   = 2'd1,
        PHASE_ARMED = 2'd2,
        PHASE_TRIG  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        TRACK_NONE   = 2'd0,
        TRACK_MOVING = 2'd1,
        TRACK_STILL  = 2'd2
    } track_t;

    typedef struct packed {
        logic [11:0] threshold;
        logic [9:0]  max_runs;
        logic [15:0] reset_ticks;
    } cfg_t;

    typedef struct packed {
        logic clear;  // empty the window before this beat's sample
        logic push;   // add this beat's sample
    } win_cmd_t;

    typedef struct packed {
        phase_t             phase;
        track_t             track;
        logic               pulse;
        logic signed [15:0] min_angle;
        logic signed [15:0] max_angle;
    } result_t;

endpackage

@@ src/self_calibrating_rotation_alarm.sv @@
// Rotation alarm top level: input register, config, control, window, result register.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------------------------------
//  sample   | sample_valid / sample_stall | yaw, tracker_visible, reset_request
//  result   | result_valid / result_stall | phase_status, tracker_status, trigger_pulse,
//           |                             | min_angle, max_angle
//  config   | psel, penable, pwrite       | paddr, pwdata, prdata (pready tied high)
//
//  One beat per cycle unless results stall; a sample passes input, then result register.
//  All state updates per beat from the input register, via the window sum and compare.
//  Reset clears the phase state and empties the window; no clearing pass is needed.
//  A stalled result holds; the input register keeps one more beat, then sample_stall rises.
module self_calibrating_rotation_alarm #(
    parameter int WINDOW = scra_pkg::SCRA_WINDOW
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  logic signed [15:0]  yaw,
    input  logic                tracker_visible,
    input  logic                reset_request,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [1:0]          phase_status,
    output logic [1:0]          tracker_status,
    output logic                trigger_pulse,
    output logic signed [15:0]  min_angle,
    output logic signed [15:0]  max_angle,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import scra_pkg::*;

    logic               s1_valid_reg;
    logic signed [15:0] s1_yaw_reg;
    logic               s1_vis_reg;
    logic               s1_req_reg;
    logic               result_valid_reg;
    result_t            result_reg;

    logic               advance;
    logic               step;
    logic               accept;
    cfg_t               cfg;
    win_cmd_t           cmd;
    result_t            res;
    logic               moving;

    assign advance      = !result_valid_reg || !result_stall;
    assign step         = s1_valid_reg && advance;
    assign sample_stall = s1_valid_reg && !advance;
    assign accept       = sample_valid && !sample_stall;

    scra_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    scra_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .yaw       (s1_yaw_reg),
        .threshold (cfg.threshold),
        .moving    (moving)
    );

    scra_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .yaw     (s1_yaw_reg),
        .visible (s1_vis_reg),
        .req     (s1_req_reg),
        .cfg     (cfg),
        .moving  (moving),
        .cmd     (cmd),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (step)
                s1_valid_reg <= 1'b0;

            if (step)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_yaw_reg <= yaw;
            s1_vis_reg <= tracker_visible;
            s1_req_reg <= reset_request;
        end
        if (step)
            result_reg <= res;
    end

    assign result_valid   = result_valid_reg;
    assign phase_status   = result_reg.phase;
    assign tracker_status = result_reg.track;
    assign trigger_pulse  = result_reg.pulse;
    assign min_angle      = result_reg.min_angle;
    assign max_angle      = result_reg.max_angle;

    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (result_valid_reg && result_stall))
        else $error("input held while result slot free");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |=> (result_valid_reg && $stable(result_reg)))
        else $error("stalled result lost or changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.clear || cmd.push) |-> step)
        else $error("window updated without a beat");

endmodule

@@ src/scra_cfg.sv @@
// APB register file: threshold, max_runs, reset_ticks.
module scra_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output scra_pkg::cfg_t      cfg
);
    import scra_pkg::*;

    logic [11:0] threshold_reg;
    logic [9:0]  max_runs_reg;
    logic [15:0] reset_ticks_reg;
    logic        wr_en;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= THRESHOLD_RST;
            max_runs_reg    <= MAX_RUNS_RST;
            reset_ticks_reg <= RESET_TICKS_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_THRESHOLD:   threshold_reg   <= pwdata[11:0];
                REG_MAX_RUNS:    max_runs_reg    <= pwdata[9:0];
                REG_RESET_TICKS: reset_ticks_reg <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_THRESHOLD:   prdata = {20'd0, threshold_reg};
            REG_MAX_RUNS:    prdata = {22'd0, max_runs_reg};
            REG_RESET_TICKS: prdata = {16'd0, reset_ticks_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg.threshold   = threshold_reg;
    assign cfg.max_runs    = max_runs_reg;
    assign cfg.reset_ticks = reset_ticks_reg;

endmodule

@@ src/scra_window.sv @@
// Sliding yaw window with running sum and the division-free movement test.
module scra_window #(
    parameter int WINDOW = scra_pkg::SCRA_WINDOW
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scra_pkg::win_cmd_t   cmd,
    input  logic signed [15:0]   yaw,
    input  logic [11:0]          threshold,
    output logic                 moving
);
    import scra_pkg::*;

    localparam int HW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FW = $clog2(WINDOW + 1);
    localparam int SW = 16 + HW;
    localparam int DW = SW + 2;
    localparam logic [HW-1:0]        LAST  = HW'(WINDOW - 1);
    localparam logic [FW-1:0]        FULL  = FW'(WINDOW);
    localparam logic signed [DW-1:0] WIN_S = DW'(WINDOW);
    localparam logic [DW-1:0]        LIM_K = DW'(MOVE_FACTOR * WINDOW);

    logic signed [15:0]   yaw_window_reg [WINDOW];
    logic signed [SW-1:0] window_sum_reg;
    logic [FW-1:0]        window_fill_reg;
    logic [HW-1:0]        window_head_reg;

    logic [FW-1:0]        eff_fill;
    logic [HW-1:0]        eff_head;
    logic signed [SW-1:0] eff_sum;
    logic                 full_before;
    logic signed [15:0]   old_yaw;
    logic signed [SW-1:0] window_sum_next;
    logic [FW-1:0]        window_fill_next;
    logic [HW-1:0]        window_head_next;
    logic signed [DW-1:0] scaled_yaw;
    logic signed [DW-1:0] diff;
    logic [DW-1:0]        diff_mag;
    logic [DW-1:0]        limit;

    always_comb
    begin
        eff_fill    = cmd.clear ? '0 : window_fill_reg;
        eff_head    = cmd.clear ? '0 : window_head_reg;
        eff_sum     = cmd.clear ? '0 : window_sum_reg;
        full_before = (eff_fill == FULL);
        old_yaw     = full_before ? yaw_window_reg[eff_head] : 16'sd0;

        window_sum_next  = eff_sum - SW'(old_yaw) + SW'(yaw);
        window_fill_next = full_before ? eff_fill : eff_fill + 1'b1;
        window_head_next = (eff_head == LAST) ? '0 : eff_head + 1'b1;

        // |sum - N*yaw| > 5*thr*N stands in for |mean - yaw| > 5*thr
        scaled_yaw = DW'(yaw) * WIN_S;
        diff       = DW'(window_sum_next) - scaled_yaw;
        diff_mag   = diff[DW-1] ? DW'(-diff) : DW'(diff);
        limit      = DW'(threshold) * LIM_K;

        moving = cmd.push && (window_fill_next == FULL) && (diff_mag > limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_sum_reg  <= '0;
            window_fill_reg <= '0;
            window_head_reg <= '0;
        end
        else if (cmd.push && !moving)
        begin
            window_sum_reg  <= window_sum_next;
            window_fill_reg <= window_fill_next;
            window_head_reg <= window_head_next;
        end
        else if (cmd.push || cmd.clear)
        begin
            window_sum_reg  <= '0;
            window_fill_reg <= '0;
            window_head_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push && !moving)
        begin
            yaw_window_reg[eff_head] <= yaw;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        window_fill_reg <= FULL)
        else $error("window fill beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (window_fill_reg != FULL) |-> (window_head_reg == HW'(window_fill_reg)))
        else $error("window head out of step with fill");

endmodule

@@ src/scra_ctrl.sv @@
// Phase control: reset timer, calibration extremes, arming and trigger.
module scra_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic signed [15:0]   yaw,
    input  logic                 visible,
    input  logic                 req,
    input  scra_pkg::cfg_t       cfg,
    input  logic                 moving,
    output scra_pkg::win_cmd_t   cmd,
    output scra_pkg::result_t    res
);
    import scra_pkg::*;

    logic [RUN_W-1:0]   run_count_reg,   run_count_next;
    logic signed [15:0] lowest_yaw_reg,  lowest_yaw_next;
    logic signed [15:0] highest_yaw_reg, highest_yaw_next;
    logic [15:0]        timer_count_reg, timer_count_next;
    logic               timer_active_reg, timer_active_next;

    logic               go_idle;
    logic               push;
    logic [RUN_W-1:0]   runs;
    logic [15:0]        timer_dec;
    logic signed [17:0] low_bound;
    logic signed [17:0] high_bound;
    logic signed [17:0] yaw_x;

    always_comb
    begin
        runs = (cfg.max_runs == '0) ? RUN_W'(1) : RUN_W'(cfg.max_runs);

        timer_active_next = timer_active_reg;
        timer_count_next  = timer_count_reg;
        go_idle           = 1'b0;
        timer_dec         = (timer_count_reg != '0) ? timer_count_reg - 1'b1 : timer_count_reg;

        if (timer_active_reg)
        begin
            timer_count_next = timer_dec;
            if (timer_dec == '0)
            begin
                timer_active_next = 1'b0;
                go_idle           = 1'b1;
            end
        end
        if (req)
        begin
            timer_active_next = 1'b0;
            timer_count_next  = '0;
            go_idle           = 1'b1;
        end

        run_count_next   = go_idle ? '0 : run_count_reg;
        lowest_yaw_next  = go_idle ? POS_SENTINEL : lowest_yaw_reg;
        highest_yaw_next = go_idle ? NEG_SENTINEL : highest_yaw_reg;

        push       = visible && (run_count_next < runs);
        yaw_x      = 18'(yaw);
        low_bound  = 18'(lowest_yaw_next) - 18'(signed'({1'b0, cfg.threshold}));
        high_bound = 18'(highest_yaw_next) + 18'(signed'({1'b0, cfg.threshold}));

        res.phase     = PHASE_WAIT;
        res.track     = TRACK_NONE;
        res.pulse     = 1'b0;

        if (visible)
        begin
            if (push)
            begin
                res.phase = PHASE_CAL;
                if (moving)
                begin
                    res.track        = TRACK_MOVING;
                    run_count_next   = '0;
                    lowest_yaw_next  = POS_SENTINEL;
                    highest_yaw_next = NEG_SENTINEL;
                end
                else
                begin
                    res.track = TRACK_STILL;
                    if (yaw < lowest_yaw_next)
                        lowest_yaw_next = yaw;
                    if (yaw > highest_yaw_next)
                        highest_yaw_next = yaw;
                    run_count_next = run_count_next + 1'b1;
                end
            end
            else if (run_count_next == runs)
            begin
                // arming beat: no measurement
                run_count_next = runs + 1'b1;
                res.phase      = PHASE_ARMED;
                res.track      = TRACK_STILL;
            end
            else
            begin
                res.track = TRACK_STILL;
                if ((yaw_x < low_bound || yaw_x > high_bound) && !timer_active_next)
                begin
                    timer_active_next = 1'b1;
                    timer_count_next  = (cfg.reset_ticks == '0) ? 16'd1 : cfg.reset_ticks;
                    res.pulse         = 1'b1;
                end
                res.phase = timer_active_next ? PHASE_TRIG : PHASE_ARMED;
            end
        end

        res.min_angle = lowest_yaw_next;
        res.max_angle = highest_yaw_next;

        cmd.clear = step && go_idle;
        cmd.push  = step && push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_count_reg    <= '0;
            lowest_yaw_reg   <= POS_SENTINEL;
            highest_yaw_reg  <= NEG_SENTINEL;
            timer_count_reg  <= '0;
            timer_active_reg <= 1'b0;
        end
        else if (step)
        begin
            run_count_reg    <= run_count_next;
            lowest_yaw_reg   <= lowest_yaw_next;
            highest_yaw_reg  <= highest_yaw_next;
            timer_count_reg  <= timer_count_next;
            timer_active_reg <= timer_active_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        timer_active_reg |-> (timer_count_reg != '0))
        else $error("timer active with zero count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (run_count_reg != '0) |-> (lowest_yaw_reg <= highest_yaw_reg))
        else $error("calibrated extremes crossed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.pulse) |=> timer_active_reg)
        else $error("trigger did not start the timer");

endmodule
